/* hdl/salwc_pkg.sv */
// Shared types and constants of the set-associative LRU walk cache.
package salwc_pkg;

   localparam int KEY_W       = 32;
   localparam int APP_W       = 4;
   localparam int SETNUM_W    = 4;
   localparam int TYPE_W      = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   localparam logic [TYPE_W-1:0] REQ_ACCESS = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FILL   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FLUSH  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

/* hdl/salwc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module salwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/set_assoc_lru_walk_cache_unit.sv */
// Top level of the set-associative page walk cache with true LRU order per set.
//
// Channel  Dir  Beat holds
// req_     in   tuser: req_type; tdata: lookup_key, set_number, flush_app
// rsp_     out  tdata: hit
//
// An access or fill runs from the accepted beat back to ready through one set row
// read, one key compare per way on the shared comparator and one write.
// A flush reads, scans and writes every set in turn.
// Other request types and out-of-range sets go straight to the finish state.
// Reset clears all valid bits at once; keys and ranks need no clearing pass.
// A result waits in the output register while the next beat is accepted; a
// finished item waits for that register to empty.
module set_assoc_lru_walk_cache_unit #(
   parameter int SETS = 16,
   parameter int WAYS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_type
   input  logic [salwc_pkg::TYPE_W-1:0]        req_tuser,
   // lookup_key, set_number, flush_app
   input  logic [salwc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit
   output logic [salwc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   import salwc_pkg::*;

   localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int KEYS_W = WAYS * KEY_W;
   localparam int ROW_W = WAYS * (KEY_W + RW);

   state_type state_ff, state_in;

   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [APP_W-1:0]    app_ff, app_in;
   logic [SW-1:0]       set_ff, set_in;
   logic [KEY_W-1:0]    keys_ff [WAYS];
   logic [KEY_W-1:0]    keys_in [WAYS];
   logic [RW-1:0]       ranks_ff [WAYS];
   logic [RW-1:0]       ranks_in [WAYS];
   logic [WAYS-1:0]     vrow_ff, vrow_in;
   logic [WW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [WW-1:0]       fway_ff, fway_in;
   logic [WW-1:0]       vway_ff, vway_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [WAYS-1:0]     valid_ff [SETS];

   logic [KEY_W-1:0]    req_key;
   logic [SETNUM_W-1:0] req_set;
   logic [APP_W-1:0]    req_app;
   logic [SW+SETNUM_W-1:0] req_set_ext;
   logic                req_in_range;
   logic                accept;

   logic [SW-1:0]       rd_addr;
   logic [ROW_W-1:0]    rd_data;
   logic                wr_en;
   logic [ROW_W-1:0]    wr_data;

   logic                is_flush;
   logic [KEY_W-1:0]    cmp_key;
   logic [KEY_W-1:0]    cmp_ref;
   logic [KEY_W-1:0]    cmp_mask;
   logic                cmp_match;
   logic                scan_last;

   logic                row_full;
   logic                drop;
   logic [WW-1:0]       dway;
   logic [RW-1:0]       bound_rank;
   logic [WAYS-1:0]     vrow_free;
   logic [WW-1:0]       ins_way;
   logic [KEY_W-1:0]    new_keys [WAYS];
   logic [RW-1:0]       new_ranks [WAYS];
   logic [WAYS-1:0]     new_vrow;

   assign req_key     = req_tdata[KEY_W-1:0];
   assign req_set     = req_tdata[KEY_W+SETNUM_W-1:KEY_W];
   assign req_app     = req_tdata[KEY_W+SETNUM_W+APP_W-1:KEY_W+SETNUM_W];
   assign req_set_ext = {{SW{1'b0}}, req_set};
   assign req_in_range = ({{(32-SETNUM_W){1'b0}}, req_set} < 32'(SETS));
   assign accept      = req_tvalid && req_tready;
   assign is_flush    = (type_ff == REQ_FLUSH);
   assign scan_last   = (idx_ff == WW'(WAYS - 1));

   // Shared key comparator, stepped over the ways of the loaded row.
   assign cmp_key   = keys_ff[idx_ff];
   assign cmp_ref   = is_flush ? {{(KEY_W-APP_W){1'b0}}, app_ff} : key_ff;
   assign cmp_mask  = is_flush ? {{(KEY_W-APP_W){1'b0}}, {APP_W{1'b1}}} : {KEY_W{1'b1}};
   assign cmp_match = vrow_ff[idx_ff] && (((cmp_key ^ cmp_ref) & cmp_mask) == '0);

   // Row update for an access, fill or flush.
   always_comb begin
      row_full   = &vrow_ff;
      drop       = found_ff || row_full;
      dway       = found_ff ? fway_ff : vway_ff;
      bound_rank = found_ff ? ranks_ff[fway_ff] : RW'(WAYS - 1);
      vrow_free  = vrow_ff;
      if (drop) begin
         vrow_free[dway] = 1'b0;
      end
      ins_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!vrow_free[w]) begin
            ins_way = WW'(w);
         end
      end
      if ((type_ff == REQ_ACCESS) && found_ff) begin
         ins_way = fway_ff;
      end
      new_vrow = vrow_free;
      for (int v = 0; v < WAYS; v++) begin
         new_keys[v]  = keys_ff[v];
         new_ranks[v] = ranks_ff[v];
         if (vrow_ff[v] && !(drop && (dway == WW'(v))) &&
             (!drop || (ranks_ff[v] < bound_rank))) begin
            new_ranks[v] = ranks_ff[v] + RW'(1);
         end
      end
      if (!is_flush) begin
         new_vrow[ins_way]  = 1'b1;
         new_keys[ins_way]  = key_ff;
         new_ranks[ins_way] = '0;
      end else begin
         new_vrow = vrow_ff;
         for (int v = 0; v < WAYS; v++) begin
            new_ranks[v] = ranks_ff[v];
         end
      end
   end

   always_comb begin
      for (int v = 0; v < WAYS; v++) begin
         wr_data[v*KEY_W +: KEY_W]       = new_keys[v];
         wr_data[KEYS_W + v*RW +: RW]    = new_ranks[v];
      end
   end

   assign wr_en = (state_ff == ST_UPDATE);

   salwc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (set_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_tuser == REQ_FLUSH) ||
                   (((req_tuser == REQ_ACCESS) || (req_tuser == REQ_FILL)) && req_in_range)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (is_flush && (set_ff != SW'(SETS - 1))) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      type_in      = type_ff;
      key_in       = key_ff;
      app_in       = app_ff;
      set_in       = set_ff;
      vrow_in      = vrow_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      fway_in      = fway_ff;
      vway_in      = vway_ff;
      hit_in       = hit_ff;
      rd_addr      = set_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int v = 0; v < WAYS; v++) begin
         keys_in[v]  = keys_ff[v];
         ranks_in[v] = ranks_ff[v];
      end
      case (state_ff)
         ST_IDLE: begin
            type_in = req_tuser;
            key_in  = req_key;
            app_in  = req_app;
            hit_in  = 1'b0;
            set_in  = (req_tuser == REQ_FLUSH) ? '0 : req_set_ext[SW-1:0];
            rd_addr = set_in;
         end
         ST_LOAD: begin
            vrow_in  = valid_ff[set_ff];
            idx_in   = '0;
            found_in = 1'b0;
            fway_in  = '0;
            vway_in  = '0;
            for (int v = 0; v < WAYS; v++) begin
               keys_in[v]  = rd_data[v*KEY_W +: KEY_W];
               ranks_in[v] = rd_data[KEYS_W + v*RW +: RW];
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + WW'(1);
            if (is_flush) begin
               if (cmp_match) begin
                  vrow_in[idx_ff] = 1'b0;
                  for (int v = 0; v < WAYS; v++) begin
                     if (vrow_ff[v] && (ranks_ff[v] > ranks_ff[idx_ff])) begin
                        ranks_in[v] = ranks_ff[v] - RW'(1);
                     end
                  end
               end
            end else begin
               if (cmp_match && !found_ff) begin
                  found_in = 1'b1;
                  fway_in  = idx_ff;
               end
               if (vrow_ff[idx_ff] && (ranks_ff[idx_ff] == RW'(WAYS - 1))) begin
                  vway_in = idx_ff;
               end
            end
         end
         ST_UPDATE: begin
            hit_in = (type_ff == REQ_ACCESS) && found_ff;
            if (is_flush && (set_ff != SW'(SETS - 1))) begin
               set_in  = set_ff + SW'(1);
               rd_addr = set_in;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
            end
         end
         default: begin
            rd_addr = set_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_UPDATE) begin
            valid_ff[set_ff] <= new_vrow;
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      key_ff     <= key_in;
      app_ff     <= app_in;
      set_ff     <= set_in;
      vrow_ff    <= vrow_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      fway_ff    <= fway_in;
      vway_ff    <= vway_in;
      hit_ff     <= hit_in;
      rsp_hit_ff <= rsp_hit_in;
      for (int v = 0; v < WAYS; v++) begin
         keys_ff[v]  <= keys_in[v];
         ranks_ff[v] <= ranks_in[v];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_hit_ff};

endmodule

/* hdl/salwc_checker.sv */
// Port-level checker of the walk cache, bound to the top level.
module salwc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [salwc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_tvalid && req_tready) begin
         cnt_in = cnt_in + 2'd1;
      end
      if (rsp_tvalid && rsp_tready) begin
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 2'd0)
      else $error("result beat without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> cnt_ff < 2'd2)
      else $error("request accepted with two items outstanding");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind set_assoc_lru_walk_cache_unit salwc_checker u_salwc_checker (.*);
